// File: design/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared types, round constants and the round function.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

   localparam int unsigned ROUNDS  = 80;
   localparam int unsigned ROUND_W = 7;

   typedef logic [31:0]      word_type;
   typedef logic [4:0][31:0] chain_type;   // [0] is word A / digest word 0

   localparam chain_type H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

   localparam word_type K_0 = 32'h5A827999;
   localparam word_type K_1 = 32'h6ED9EBA1;
   localparam word_type K_2 = 32'h8F1BBCDC;
   localparam word_type K_3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // control from the sequencer to the schedule window
   typedef struct packed {
      logic       push;     // pack one byte
      logic [7:0] data;
      logic       step;     // advance one round
      logic       expand;   // round 16 and up: compute a new schedule word
   } sched_ctrl_type;

   function automatic word_type round_f(logic [ROUND_W-1:0] idx, word_type b,
                                        word_type c, word_type d);
      word_type f;
      if (idx < ROUND_W'(20)) begin
         f = d ^ (b & (c ^ d));
      end else if (idx < ROUND_W'(40)) begin
         f = b ^ c ^ d;
      end else if (idx < ROUND_W'(60)) begin
         f = (b & c) | (d & (b | c));
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(logic [ROUND_W-1:0] idx);
      word_type k;
      if (idx < ROUND_W'(20)) begin
         k = K_0;
      end else if (idx < ROUND_W'(40)) begin
         k = K_1;
      end else if (idx < ROUND_W'(60)) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

endpackage

// File: design/sha1sh_sched.sv
// ----------------------------------------------------------------------------
// SHA-1 message schedule window
// Packs bytes big-endian into words and holds the 16-word window as a shift
// line; during compression it recirculates or expands one word per round.
// ----------------------------------------------------------------------------
module sha1sh_sched (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1sh_pkg::sched_ctrl_type ctrl,
   output sha1sh_pkg::word_type     w
);

   sha1sh_pkg::word_type window_ff [0:15];
   sha1sh_pkg::word_type window_in [0:15];
   logic [23:0]          acc_ff, acc_in;
   logic [1:0]           cnt_ff, cnt_in;
   sha1sh_pkg::word_type mix;

   // window holds W[i-16..i-1] at taps 0..15
   assign mix = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
   assign w   = ctrl.expand ? {mix[30:0], mix[31]} : window_ff[0];

   always_comb begin
      window_in = window_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (ctrl.push) begin
         acc_in = {acc_ff[15:0], ctrl.data};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[15] = {acc_ff, ctrl.data};
         end
      end else if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[15] = w;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      acc_ff    <= acc_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: design/sha1sh_rounds.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working words A..E and the one shared round datapath, stepped once per cycle while step is high.
// ----------------------------------------------------------------------------
module sha1sh_rounds (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic                                   step,
   input  logic [sha1sh_pkg::ROUND_W-1:0]         round_idx,
   input  sha1sh_pkg::word_type                   w,
   input  sha1sh_pkg::chain_type                  chain,
   output sha1sh_pkg::chain_type                  work
);

   sha1sh_pkg::chain_type work_ff, work_in;
   sha1sh_pkg::word_type  a, b, c, d, e, t;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   assign t = {a[26:0], a[31:27]} + sha1sh_pkg::round_f(round_idx, b, c, d) + e
            + sha1sh_pkg::round_k(round_idx) + w;

   always_comb begin
      work_in = work_ff;
      if (load) begin
         work_in = chain;
      end else if (step) begin
         work_in[0] = t;
         work_in[1] = a;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[3] = c;
         work_in[4] = d;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

// File: design/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte stream in, five 32-bit digest words out per message.
// Flow: one byte beat per cycle while idle; the 64th byte of a block starts
// a compression of 80 rounds on the single round unit plus a chaining add,
// and no input is taken until it ends. End of message: one padding/length byte
// per cycle (up to 72) plus one or two compressions, then 5 result beats.
// Reset (synchronous): chaining words to the SHA-1 IV, counters to zero.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      S_IDLE, S_COMP, S_ADD, S_PAD, S_LEN, S_OUT
   } state_type;

   localparam int unsigned RW = sha1sh_pkg::ROUND_W;

   state_type                 state_ff, state_in;
   sha1sh_pkg::chain_type     chain_ff, chain_in;
   logic [5:0]                fill_ff, fill_in;
   logic [60:0]               count_ff, count_in;
   logic [63:0]               len_ff, len_in;
   logic [RW-1:0]             round_ff, round_in;
   logic [2:0]                idx_ff, idx_in;
   logic                      finishing_ff, finishing_in;
   logic                      pad_first_ff, pad_first_in;
   logic                      len_phase_ff, len_phase_in;

   logic                      req_beat, rsp_beat, load;
   logic [60:0]               count_plus;
   sha1sh_pkg::sched_ctrl_type sched_ctrl;
   sha1sh_pkg::word_type      w;
   sha1sh_pkg::chain_type     work;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = chain_ff[0];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 3'd4);
   assign count_plus = count_ff + 61'(req_tuser);

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      finishing_in = finishing_ff;
      pad_first_in = pad_first_ff;
      len_phase_in = len_phase_ff;
      load         = 1'b0;
      sched_ctrl   = '0;

      case (state_ff)
         S_IDLE: begin
            sched_ctrl.data = req_tdata;
            if (req_beat) begin
               if (req_tuser) begin
                  sched_ctrl.push = 1'b1;
                  fill_in         = fill_ff + 6'd1;
                  count_in        = count_plus;
               end
               if (req_tlast) begin
                  finishing_in = 1'b1;
                  pad_first_in = 1'b1;
                  len_in       = {count_plus, 3'b000};
                  count_in     = '0;
                  state_in     = S_PAD;
               end
               // a full block takes priority; padding resumes after it
               if (req_tuser && fill_ff == 6'd63) begin
                  load     = 1'b1;
                  round_in = '0;
                  state_in = S_COMP;
               end
            end
         end
         S_COMP: begin
            sched_ctrl.step   = 1'b1;
            sched_ctrl.expand = (round_ff >= RW'(16));
            round_in          = round_ff + RW'(1);
            if (round_ff == RW'(sha1sh_pkg::ROUNDS - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work[i];
            end
            if (!finishing_ff) begin
               state_in = S_IDLE;
            end else if (len_phase_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            sched_ctrl.push = 1'b1;
            sched_ctrl.data = pad_first_ff ? sha1sh_pkg::PAD_BYTE : 8'h00;
            pad_first_in    = 1'b0;
            fill_in         = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               load     = 1'b1;
               round_in = '0;
               state_in = S_COMP;
            end else if (fill_ff == 6'd55) begin
               len_phase_in = 1'b1;
               state_in     = S_LEN;
            end
         end
         S_LEN: begin
            sched_ctrl.push = 1'b1;
            sched_ctrl.data = len_ff[63:56];
            len_in          = {len_ff[55:0], 8'h00};
            fill_in         = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               load     = 1'b1;
               round_in = '0;
               state_in = S_COMP;
            end
         end
         S_OUT: begin
            if (rsp_beat) begin
               // shift digest out word by word, refilling with the IV
               for (int i = 0; i < 4; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               chain_in[4] = sha1sh_pkg::H_INIT[idx_ff];
               idx_in      = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  idx_in       = 3'd0;
                  finishing_in = 1'b0;
                  len_phase_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      round_ff <= round_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         chain_ff     <= sha1sh_pkg::H_INIT;
         fill_ff      <= 6'd0;
         count_ff     <= '0;
         idx_ff       <= 3'd0;
         finishing_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         len_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         finishing_ff <= finishing_in;
         pad_first_ff <= pad_first_in;
         len_phase_ff <= len_phase_in;
      end
   end

   sha1sh_sched u_sched (
      .clock (clock),
      .reset (reset),
      .ctrl  (sched_ctrl),
      .w     (w)
   );

   sha1sh_rounds u_rounds (
      .clock     (clock),
      .load      (load),
      .step      (sched_ctrl.step),
      .round_idx (round_ff),
      .w         (w),
      .chain     (chain_ff),
      .work      (work)
   );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Feeds byte streams split into messages (short ones, empty ones, and lengths
// around the one- and two-block padding boundaries). A built-in SHA-1
// predictor computes each digest, and every digest word beat is checked in
// order against it. Both stream sides idle at random, with one long stall on
// the result side so that the input backs up.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HALF_PERIOD  = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_AFTER  = 340;
   localparam int DRAIN_CYCLES = 30;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   typedef struct {
      bit [31:0] word;
      bit [2:0]  index;
      bit        last;
   } digest_beat_type;

   class digest_scoreboard;
      digest_beat_type digest_queue[$];
      bit [31:0]       chain[5];
      bit [7:0]        block_bytes[64];
      bit [60:0]       byte_count;
      int              errors;
      int              messages;
      int              bytes_seen;
      int              words_checked;

      function new();
         foreach (block_bytes[i]) block_bytes[i] = 8'h00;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 5; i++) chain[i] = sha1sh_pkg::H_INIT[i];
         byte_count = '0;
      endfunction

      function void sha1_compress();
         bit [31:0] w[16];
         bit [31:0] a, b, c, d, e, f, k, t, x;
         for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int i = 0; i < 80; i++) begin
            if (i >= 16) begin
               x = w[(i-3) & 15] ^ w[(i-8) & 15] ^ w[(i-14) & 15] ^ w[i & 15];
               w[i & 15] = {x[30:0], x[31]};
            end
            if (i < 20) begin
               f = d ^ (b & (c ^ d));
               k = sha1sh_pkg::K_0;
            end else if (i < 40) begin
               f = b ^ c ^ d;
               k = sha1sh_pkg::K_1;
            end else if (i < 60) begin
               f = (b & c) | (d & (b | c));
               k = sha1sh_pkg::K_2;
            end else begin
               f = b ^ c ^ d;
               k = sha1sh_pkg::K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      // pad with 0x80, zeros and the bit length; one or two final blocks
      function void close_message();
         int               pos;
         bit [63:0]        bit_len;
         digest_beat_type  beat;
         pos     = int'(byte_count[5:0]);
         bit_len = {byte_count, 3'b000};
         block_bytes[pos] = sha1sh_pkg::PAD_BYTE;
         for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
         if (pos >= 56) begin
            sha1_compress();
            for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
         sha1_compress();
         for (int i = 0; i < 5; i++) begin
            beat.word  = chain[i];
            beat.index = 3'(i);
            beat.last  = (3'(i) == LAST_INDEX);
            digest_queue.push_back(beat);
         end
         messages++;
         restart();
      endfunction

      function void note_input(bit [7:0] data, bit has_byte, bit eom);
         int pos;
         if (has_byte) begin
            pos = int'(byte_count[5:0]);
            block_bytes[pos] = data;
            byte_count++;
            bytes_seen++;
            if (pos == 63) sha1_compress();
         end
         if (eom) close_message();
      endfunction

      function void check_digest_word(bit [31:0] word, bit [2:0] index, bit last);
         digest_beat_type want;
         if (digest_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest beat, expected none, actual %h idx %0d last %0b",
                     $time, word, index, last);
            return;
         end
         want = digest_queue.pop_front();
         words_checked++;
         if (want.word != word) begin
            errors++;
            $display("%0t: digest word mismatch, expected %h actual %h",
                     $time, want.word, word);
         end
         if (want.index != index) begin
            errors++;
            $display("%0t: word index mismatch, expected %0d actual %0d",
                     $time, want.index, index);
         end
         if (want.last != last) begin
            errors++;
            $display("%0t: last word mismatch, expected %0b actual %0b",
                     $time, want.last, last);
         end
      endfunction

      function int pending();
         return digest_queue.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] has_byte
   logic        req_tlast = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_index
   logic        rsp_tlast;           // last_word

   digest_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int items_sent = 0;
   int sink_burst = 0;

   sha1_stream_hasher_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   initial begin
      #(HALF_PERIOD * 2 * 250_000);
      $display("sha1_stream_hasher_top regression: fail");
      $finish;
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (sink_burst > 0) begin
            rsp_tready = 1'b0;
            sink_burst--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            sink_burst = $urandom_range(1, 13) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_digest_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   task automatic send_item(input bit [7:0] data, input bit has_byte, input bit eom);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = data;
      req_tuser  = has_byte;
      req_tlast  = eom;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_input(data, has_byte, eom);
      if (has_byte || eom) items_sent++;
   endtask

   function automatic int pick_length();
      if ($urandom_range(0, 2) != 0) return $urandom_range(0, 40);
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return 1;
         2:       return 55;
         3:       return 56;
         4:       return 57;
         5:       return 62;
         6:       return 63;
         7:       return 64;
         8:       return 65;
         9:       return 119;
         10:      return 120;
         default: return 128;
      endcase
   endfunction

   // random message: bytes with occasional idle beats mixed in, closed either on
   // the last byte or by a separate end beat without data
   task automatic send_message(input int len);
      bit joined;
      joined = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, joined && (i == len - 1));
         if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      end
      if (!joined) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(8'hFF, 1'b0, 1'b0);        // idle beat
      send_item(8'hA5, 1'b0, 1'b1);        // empty message
      send_item(8'h61, 1'b1, 1'b0);        // "abc", end rides on the last byte
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);        // single zero byte, separate end
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);        // single all-ones byte
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h5A, 1'b0, 1'b1);        // back-to-back empty messages
      send_item(8'h00, 1'b0, 1'b1);

      hold_request = 1'b1;
      while (items_sent < RANDOM_ITEMS) send_message(pick_length());

      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d messages, %0d bytes, %0d digest words checked",
               sb.messages, sb.bytes_seen, sb.words_checked);
      $display("including empty, single-byte and padding-boundary lengths; %0d errors",
               sb.errors);
      if (sb.errors == 0) begin
         $display("sha1_stream_hasher_top regression: pass");
      end else begin
         $display("sha1_stream_hasher_top regression: fail");
      end
      $finish;
   end

endmodule
